### rtl/udp_ipv4_frame_builder_macros.svh
// assertion macros for the udp/ipv4 frame builder
// used by the top level; expects clk and rst_n in scope
`ifndef UDP_IPV4_FRAME_BUILDER_MACROS_SVH
`define UDP_IPV4_FRAME_BUILDER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define UFB_CHECK(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame builder check failed");

// next-cycle implication
`define UFB_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame builder check failed");

`else

`define UFB_CHECK(label, ante, cons)
`define UFB_CHECK_NEXT(label, ante, cons)

`endif

`endif

### rtl/ufb_pkg.sv
// shared types and constants of the udp/ipv4 frame builder
// no dependencies
package ufb_pkg;

    localparam int HDR_LEN          = 42;
    localparam int MAX_PAYLOAD_DEF  = 1472;
    localparam int MIN_FRAME_DEF    = 60;
    localparam int CFG_ADDR_W       = 6;
    localparam int CFG_DATA_W       = 64;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        start_req;
        logic [10:0] data_len;
    } in_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        logic       dropped;
    } out_t;

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } cfg_t;

    // inputs of the checksum unit
    typedef struct packed {
        logic [10:0] data_len;
        logic [15:0] ident;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
    } csum_in_t;

    typedef enum logic [2:0] {
        REG_DEST_MAC    = 3'd0,
        REG_SOURCE_MAC  = 3'd1,
        REG_SOURCE_IP   = 3'd2,
        REG_DEST_IP     = 3'd3,
        REG_SOURCE_PORT = 3'd4,
        REG_DEST_PORT   = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CSUM,
        ST_HDR,
        ST_FIRST,
        ST_PAD
    } st_t;

endpackage

### rtl/ufb_csum.sv
// ipv4 header checksum: one 16-bit end-around-carry adder, one word per cycle
// depends on ufb_pkg
module ufb_csum
    import ufb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  csum_in_t    fields,
    output logic        done,
    output logic [15:0] checksum
);

    localparam logic [3:0] LAST_WORD = 4'd9;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  word_idx_reg, word_idx_next;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] word;
    logic [16:0] sum;

    always_comb
    begin
        case (word_idx_reg)
            4'd0:    word = 16'h4500;
            4'd1:    word = 16'd28 + 16'(fields.data_len);
            4'd2:    word = fields.ident;
            4'd3:    word = 16'h0000;
            4'd4:    word = 16'h4011;
            4'd5:    word = fields.source_ip[31:16];
            4'd6:    word = fields.source_ip[15:0];
            4'd7:    word = fields.dest_ip[31:16];
            4'd8:    word = fields.dest_ip[15:0];
            default: word = 16'h0000;
        endcase
    end

    assign sum = {1'b0, acc_reg} + {1'b0, word};

    always_comb
    begin
        busy_next     = busy_reg;
        done_next     = done_reg;
        word_idx_next = word_idx_reg;
        acc_next      = acc_reg;
        if (start)
        begin
            busy_next     = 1'b1;
            done_next     = 1'b0;
            word_idx_next = '0;
            acc_next      = '0;
        end
        else if (busy_reg)
        begin
            // end-around carry keeps the ones-complement sum in 16 bits
            acc_next      = sum[15:0] + {15'd0, sum[16]};
            word_idx_next = word_idx_reg + 4'd1;
            if (word_idx_reg == LAST_WORD)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            word_idx_reg <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            done_reg     <= done_next;
            word_idx_reg <= word_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign done     = done_reg;
    assign checksum = ~acc_reg;

endmodule

### rtl/ufb_regs.sv
// apb register file for addresses, ports and mac fields
// depends on ufb_pkg
module ufb_regs
    import ufb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg, cfg_next;
    logic wr_en;

    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[CFG_ADDR_W-1:3])
                REG_DEST_MAC:    cfg_next.dest_mac    = pwdata[47:0];
                REG_SOURCE_MAC:  cfg_next.source_mac  = pwdata[47:0];
                REG_SOURCE_IP:   cfg_next.source_ip   = pwdata[31:0];
                REG_DEST_IP:     cfg_next.dest_ip     = pwdata[31:0];
                REG_SOURCE_PORT: cfg_next.source_port = pwdata[15:0];
                REG_DEST_PORT:   cfg_next.dest_port   = pwdata[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[CFG_ADDR_W-1:3])
            REG_DEST_MAC:    prdata = {16'd0, cfg_reg.dest_mac};
            REG_SOURCE_MAC:  prdata = {16'd0, cfg_reg.source_mac};
            REG_SOURCE_IP:   prdata = {32'd0, cfg_reg.source_ip};
            REG_DEST_IP:     prdata = {32'd0, cfg_reg.dest_ip};
            REG_SOURCE_PORT: prdata = {48'd0, cfg_reg.source_port};
            REG_DEST_PORT:   prdata = {48'd0, cfg_reg.dest_port};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

### rtl/udp_ipv4_frame_builder.sv
// channel   | valid     | stall     | payload
// input     | in_valid  | in_stall  | in_data  (in_t: data_byte, start_req, data_len)
// output    | out_valid | out_stall | out_data (out_t: frame_byte, frame_end, dropped)
// config    | apb: psel/penable/pwrite, 64-bit data, register i at byte 8*i
//
// payload beats pass at one per cycle while the output is not stalled; after a start beat
// the checksum runs (10 words through the single adder, then a hand-over), then the 42
// header bytes, the first payload byte and any padding leave the single output register.
// in_stall stays high from a start beat until all of those are loaded, and while padding
// follows the last payload byte. output stalls hold the register and back up into in_stall.
// reset clears control state and all config registers.
// top level of the udp/ipv4 frame builder
// depends on ufb_pkg, ufb_csum, ufb_regs and the assertion macro header
`include "udp_ipv4_frame_builder_macros.svh"

module udp_ipv4_frame_builder
    import ufb_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int MIN_FRAME   = MIN_FRAME_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_t                  out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PAD_MAX  = MIN_FRAME - HDR_LEN;
    localparam int PAD_W    = $clog2(PAD_MAX + 2);
    localparam int HDR_BITS = 8 * HDR_LEN;
    localparam logic [5:0] HDR_LAST = 6'(HDR_LEN - 1);

    st_t         state_reg, state_next;
    logic [5:0]  hdr_idx_reg, hdr_idx_next;
    logic [PAD_W-1:0] pad_left_reg, pad_left_next;
    logic        active_reg, active_next;
    logic [10:0] bytes_left_reg, bytes_left_next;
    logic [10:0] decl_len_reg, decl_len_next;
    logic [7:0]  first_byte_reg, first_byte_next;
    logic [15:0] ident_reg, ident_next;
    out_t        out_reg;
    logic        out_valid_reg;

    logic        out_free;
    logic        in_fire;
    logic        load_en;
    out_t        load_data;
    logic        csum_start;
    logic        csum_done;
    logic [15:0] csum_value;
    logic [PAD_W-1:0] pad_amt;
    logic        oversize;
    logic        last_byte;
    cfg_t        cfg;
    csum_in_t    csum_fields;
    logic [HDR_BITS-1:0] hdr_vec;
    logic [8:0]  hdr_lsb;

    ufb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    assign csum_fields = '{data_len: decl_len_reg, ident: ident_reg,
                           source_ip: cfg.source_ip, dest_ip: cfg.dest_ip};

    ufb_csum u_csum (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (csum_start),
        .fields   (csum_fields),
        .done     (csum_done),
        .checksum (csum_value)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !out_free;
    assign in_fire   = in_valid && !in_stall;
    assign oversize  = in_data.data_len > 11'(MAX_PAYLOAD);
    assign last_byte = bytes_left_reg == 11'd1;
    assign pad_amt   = (decl_len_reg < 11'(PAD_MAX)) ?
                       PAD_W'(11'(PAD_MAX) - decl_len_reg) : '0;

    // header in wire order, first byte at the top
    assign hdr_vec = {cfg.dest_mac, cfg.source_mac, 16'h0800,
                      8'h45, 8'h00, 16'd28 + 16'(decl_len_reg), ident_reg,
                      16'h0000, 8'd64, 8'd17, csum_value,
                      cfg.source_ip, cfg.dest_ip,
                      cfg.source_port, cfg.dest_port,
                      16'd8 + 16'(decl_len_reg), 16'h0000};
    assign hdr_lsb = 9'(HDR_BITS - 8) - {hdr_idx_reg, 3'b000};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && !active_reg && in_data.start_req && !oversize)
                    state_next = ST_CSUM;
                else if (in_fire && active_reg && last_byte && pad_amt != '0)
                    state_next = ST_PAD;
            end
            ST_CSUM:
            begin
                if (csum_done)
                    state_next = ST_HDR;
            end
            ST_HDR:
            begin
                if (out_free && hdr_idx_reg == HDR_LAST)
                begin
                    if (decl_len_reg != 11'd0)
                        state_next = ST_FIRST;
                    else if (pad_amt != '0)
                        state_next = ST_PAD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_FIRST:
            begin
                if (out_free)
                    state_next = (decl_len_reg == 11'd1 && pad_amt != '0) ? ST_PAD : ST_IDLE;
            end
            ST_PAD:
            begin
                if (out_free && pad_left_reg == PAD_W'(1))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        hdr_idx_next    = hdr_idx_reg;
        pad_left_next   = pad_left_reg;
        active_next     = active_reg;
        bytes_left_next = bytes_left_reg;
        decl_len_next   = decl_len_reg;
        first_byte_next = first_byte_reg;
        ident_next      = ident_reg;
        load_en         = 1'b0;
        load_data       = '0;
        csum_start      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (active_reg)
                    begin
                        load_en             = 1'b1;
                        load_data.frame_byte = in_data.data_byte;
                        load_data.frame_end  = last_byte && pad_amt == '0;
                        bytes_left_next     = bytes_left_reg - 11'd1;
                        if (last_byte)
                        begin
                            active_next   = 1'b0;
                            pad_left_next = pad_amt;
                        end
                    end
                    else if (in_data.start_req)
                    begin
                        if (oversize)
                        begin
                            // drop notice
                            load_en             = 1'b1;
                            load_data.frame_end = 1'b1;
                            load_data.dropped   = 1'b1;
                        end
                        else
                        begin
                            decl_len_next   = in_data.data_len;
                            first_byte_next = in_data.data_byte;
                            hdr_idx_next    = '0;
                            csum_start      = 1'b1;
                        end
                    end
                end
            end
            ST_CSUM:
            begin
                hdr_idx_next = '0;
            end
            ST_HDR:
            begin
                if (out_free)
                begin
                    load_en              = 1'b1;
                    load_data.frame_byte = hdr_vec[hdr_lsb +: 8];
                    load_data.frame_end  = hdr_idx_reg == HDR_LAST && decl_len_reg == 11'd0
                                           && pad_amt == '0;
                    hdr_idx_next         = hdr_idx_reg + 6'd1;
                    if (hdr_idx_reg == HDR_LAST)
                    begin
                        ident_next    = ident_reg + 16'd1;
                        pad_left_next = pad_amt;
                    end
                end
            end
            ST_FIRST:
            begin
                if (out_free)
                begin
                    load_en              = 1'b1;
                    load_data.frame_byte = first_byte_reg;
                    load_data.frame_end  = decl_len_reg == 11'd1 && pad_amt == '0;
                    active_next          = decl_len_reg != 11'd1;
                    bytes_left_next      = decl_len_reg - 11'd1;
                    pad_left_next        = pad_amt;
                end
            end
            ST_PAD:
            begin
                if (out_free)
                begin
                    load_en             = 1'b1;
                    load_data.frame_end = pad_left_reg == PAD_W'(1);
                    pad_left_next       = pad_left_reg - PAD_W'(1);
                end
            end
            default:
            begin
                load_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hdr_idx_reg    <= '0;
            pad_left_reg   <= '0;
            active_reg     <= 1'b0;
            bytes_left_reg <= '0;
            decl_len_reg   <= '0;
            ident_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hdr_idx_reg    <= hdr_idx_next;
            pad_left_reg   <= pad_left_next;
            active_reg     <= active_next;
            bytes_left_reg <= bytes_left_next;
            decl_len_reg   <= decl_len_next;
            ident_reg      <= ident_next;
            if (load_en)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        first_byte_reg <= first_byte_next;
        if (load_en)
            out_reg <= load_data;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `UFB_CHECK(drop_beat_form, out_valid_reg && out_reg.dropped,
               out_reg.frame_end && out_reg.frame_byte == 8'd0)
    `UFB_CHECK(active_only_idle, active_reg, state_reg == ST_IDLE)
    `UFB_CHECK_NEXT(ident_bumps_at_hdr_end,
                    state_reg == ST_HDR && out_free && hdr_idx_reg == HDR_LAST,
                    ident_reg == $past(ident_reg) + 16'd1)
    `UFB_CHECK(pad_count_live, state_reg == ST_PAD, pad_left_reg != '0)

endmodule
